FILE: sv/ecv_pkg.sv
// Package for the encoder count and velocity block.
// Field widths, register map and the job word passed from front to back end.
package ecv_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int SCALE_W         = 24;
  localparam int TIME_W          = 32;
  localparam int OUT_W           = 32;
  localparam int JOB_DEPTH       = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd13522696;

  typedef enum logic [0:0] {
    CMD_EDGE  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_SCALE = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic              neg;
    logic              zero_time;
    logic [TIME_W-1:0] elapsed;
    logic [OUT_W-1:0]  pos;
  } job_ctl_t;

endpackage

FILE: sv/ecv_front.sv
// Front end: takes input words, keeps the position count and query history.
// Depends on ecv_pkg; hands query jobs to the job queue.
module ecv_front #(
  parameter int COUNT_WIDTH = ecv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        cmd,
  input  logic                        chan_a_level,
  input  logic                        chan_b_level,
  input  logic [ecv_pkg::TIME_W-1:0]  time_us,
  output logic                        job_push,
  output ecv_pkg::job_ctl_t           job_ctl,
  output logic [COUNT_WIDTH-1:0]      job_mag
);

  logic [COUNT_WIDTH-1:0]     edge_count_r, edge_count_nxt;
  logic [COUNT_WIDTH-1:0]     count_last_r, count_last_nxt;
  logic [ecv_pkg::TIME_W-1:0] time_last_r, time_last_nxt;
  logic [COUNT_WIDTH-1:0]     delta;
  logic                       is_query;

  assign is_query = (ecv_pkg::cmd_t'(cmd) == ecv_pkg::CMD_QUERY);
  assign delta    = edge_count_r - count_last_r;

  always_comb begin
    job_ctl.neg       = delta[COUNT_WIDTH-1];
    job_ctl.zero_time = (time_us == time_last_r);
    job_ctl.elapsed   = time_us - time_last_r;
    job_ctl.pos       = ecv_pkg::OUT_W'($signed(edge_count_r));
    job_mag           = delta[COUNT_WIDTH-1] ? (~delta + 1'b1) : delta;
  end

  assign job_push = accept && is_query;

  always_comb begin
    edge_count_nxt = edge_count_r;
    count_last_nxt = count_last_r;
    time_last_nxt  = time_last_r;
    if (accept && !is_query) begin
      edge_count_nxt = (chan_a_level == chan_b_level) ? edge_count_r + 1'b1
                                                       : edge_count_r - 1'b1;
    end
    if (job_push) begin
      count_last_nxt = edge_count_r;
      if (!job_ctl.zero_time) begin
        time_last_nxt = time_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      count_last_r <= '0;
      time_last_r  <= '0;
    end else begin
      edge_count_r <= edge_count_nxt;
      count_last_r <= count_last_nxt;
      time_last_r  <= time_last_nxt;
    end
  end

endmodule

FILE: sv/ecv_fifo.sv
// Short job queue between the front end and the arithmetic back end.
// Depends on ecv_pkg for its depth.
module ecv_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int DEPTH = ecv_pkg::JOB_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full      = (fill_r == CW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: sv/ecv_back.sv
// Back end: shift-add multiply by the scale, restoring divide by elapsed time,
// saturation and the result register. Depends on ecv_pkg.
module ecv_back #(
  parameter int COUNT_WIDTH = ecv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  ecv_pkg::job_ctl_t            job_ctl,
  input  logic [COUNT_WIDTH-1:0]       job_mag,
  output logic                         job_take,
  input  logic [ecv_pkg::SCALE_W-1:0]  scale,
  input  logic                         res_pop,
  output logic                         res_valid,
  output logic [ecv_pkg::OUT_W-1:0]    res_vel,
  output logic [ecv_pkg::OUT_W-1:0]    res_pos
);

  localparam int SW   = ecv_pkg::SCALE_W;
  localparam int TW   = ecv_pkg::TIME_W;
  localparam int OW   = ecv_pkg::OUT_W;
  localparam int PW   = COUNT_WIDTH + SW;
  localparam int HW   = PW - TW;
  localparam int CMPW = (HW > TW) ? HW : TW;
  localparam int NW   = $clog2(TW + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  ecv_pkg::job_ctl_t ctl_r, ctl_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic [PW-1:0]     mcand_r, mcand_nxt;
  logic [SW-1:0]     sc_r, sc_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [TW-1:0]     rem_r, rem_nxt;
  logic [TW-1:0]     quo_r, quo_nxt;
  logic              sat_r, sat_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [OW-1:0]     res_vel_r, res_vel_nxt;
  logic [OW-1:0]     res_pos_r, res_pos_nxt;

  logic [TW:0]       trial;
  logic              trial_ge;
  logic              hi_ge;
  logic [OW-1:0]     limit, mag_sat, vel;
  logic              slot_free;

  assign trial    = {rem_r, quo_r[TW-1]};
  assign trial_ge = (trial >= {1'b0, ctl_r.elapsed});
  assign hi_ge    = (CMPW'(acc_r[PW-1:TW]) >= CMPW'(ctl_r.elapsed));

  always_comb begin
    limit   = ctl_r.neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    mag_sat = (sat_r || (quo_r > limit)) ? limit : quo_r;
    if (ctl_r.zero_time) begin
      vel = '0;
    end else if (ctl_r.neg) begin
      vel = ~mag_sat + 1'b1;
    end else begin
      vel = mag_sat;
    end
  end

  assign slot_free = !res_valid_r || res_pop;
  assign job_take  = (state_r == ST_IDLE) && job_valid;

  always_comb begin
    state_nxt     = state_r;
    ctl_nxt       = ctl_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    sc_nxt        = sc_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    res_valid_nxt = res_valid_r && !res_pop;
    res_vel_nxt   = res_vel_r;
    res_pos_nxt   = res_pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          ctl_nxt   = job_ctl;
          acc_nxt   = '0;
          mcand_nxt = PW'(job_mag);
          sc_nxt    = scale;
          cnt_nxt   = NW'(SW);
          sat_nxt   = 1'b0;
          state_nxt = job_ctl.zero_time ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        if (sc_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        sc_nxt    = sc_r >> 1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        sat_nxt   = hi_ge;
        rem_nxt   = TW'(acc_r >> TW);
        quo_nxt   = acc_r[TW-1:0];
        cnt_nxt   = NW'(TW);
        state_nxt = hi_ge ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? TW'(trial - {1'b0, ctl_r.elapsed}) : trial[TW-1:0];
        quo_nxt = {quo_r[TW-2:0], trial_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          res_valid_nxt = 1'b1;
          res_vel_nxt   = vel;
          res_pos_nxt   = ctl_r.pos;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ctl_r     <= ctl_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    sc_r      <= sc_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    sat_r     <= sat_nxt;
    res_vel_r <= res_vel_nxt;
    res_pos_r <= res_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_vel   = res_vel_r;
  assign res_pos   = res_pos_r;

endmodule

FILE: sv/encoder_count_and_velocity.sv
// Top level of the quadrature encoder counter with velocity estimate.
// Depends on ecv_pkg, ecv_front, ecv_fifo and ecv_back.
//
//   channel   handshake          payload
//   input     push / full        in_cmd, in_chan_a_level, in_chan_b_level, in_time_us
//   result    empty / pop        out_velocity_mrad_s, out_position_count
//   config    psel/penable/...   pwdata (rad_scale_milli at address 0)
//
// An edge word is taken and counted also while a query is being worked,
// unless the job queue is full.
// A query in the back end runs through one take, 24 multiply steps, one range check,
// 32 divide steps and one result load; an overflowing reading skips the divide, and
// equal timestamps skip to the load. The result load waits while an unread word is held.
// Two queries may wait in the job queue; full rises when it holds both.
// Reset clears the count, the query history and the queues; the scale returns to 13522696.
module encoder_count_and_velocity #(
  parameter int COUNT_WIDTH = ecv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_cmd,
  input  logic                          in_chan_a_level,
  input  logic                          in_chan_b_level,
  input  logic [ecv_pkg::TIME_W-1:0]    in_time_us,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [ecv_pkg::OUT_W-1:0] out_velocity_mrad_s,
  output logic signed [ecv_pkg::OUT_W-1:0] out_position_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecv_pkg::PADDR_W-1:0]   paddr,
  input  logic [ecv_pkg::PDATA_W-1:0]   pwdata,
  output logic [ecv_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int JW = $bits(ecv_pkg::job_ctl_t) + COUNT_WIDTH;

  logic [ecv_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic                        reg_sel;
  logic                        wr_en;
  logic                        accept;
  logic                        job_push, job_full, job_valid, job_take;
  ecv_pkg::job_ctl_t           front_ctl, back_ctl;
  logic [COUNT_WIDTH-1:0]      front_mag, back_mag;
  logic [JW-1:0]               job_rdata;
  logic                        res_valid;
  logic [ecv_pkg::OUT_W-1:0]   res_vel, res_pos;

  assign pready  = 1'b1;
  assign reg_sel = (ecv_pkg::reg_idx_t'(paddr[2]) == ecv_pkg::REG_SCALE);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? ecv_pkg::PDATA_W'(scale_r) : '0;

  always_comb begin
    scale_nxt = scale_r;
    if (wr_en) begin
      scale_nxt = pwdata[ecv_pkg::SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ecv_pkg::SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  assign full   = job_full;
  assign accept = push && !full;

  ecv_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (in_cmd),
    .chan_a_level (in_chan_a_level),
    .chan_b_level (in_chan_b_level),
    .time_us      (in_time_us),
    .job_push     (job_push),
    .job_ctl      (front_ctl),
    .job_mag      (front_mag)
  );

  ecv_fifo #(
    .WIDTH (JW)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .wdata     ({front_ctl, front_mag}),
    .full      (job_full),
    .pop       (job_take),
    .not_empty (job_valid),
    .rdata     (job_rdata)
  );

  assign back_ctl = job_rdata[JW-1:COUNT_WIDTH];
  assign back_mag = job_rdata[COUNT_WIDTH-1:0];

  ecv_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ctl   (back_ctl),
    .job_mag   (back_mag),
    .job_take  (job_take),
    .scale     (scale_r),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res_vel   (res_vel),
    .res_pos   (res_pos)
  );

  assign empty               = !res_valid;
  assign out_velocity_mrad_s = res_vel;
  assign out_position_count  = res_pos;

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_query_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ecv_pkg::cmd_t'(in_cmd) == ecv_pkg::CMD_QUERY)) |-> job_push)
    else $error("accepted query not queued");

  a_edge_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ecv_pkg::cmd_t'(in_cmd) == ecv_pkg::CMD_EDGE)) |-> !job_push)
    else $error("edge word queued as a job");

endmodule

FILE: test/encoder_count_and_velocity_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for encoder_count_and_velocity: edge and query words in, velocity
// readings out, each reading checked against an in-bench count and rate calculation.
// Depends on ecv_pkg and the encoder_count_and_velocity RTL.
module encoder_count_and_velocity_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 80;
  localparam int SPARE_REG   = 1;

  typedef struct packed {
    logic signed [ecv_pkg::OUT_W-1:0] velocity;
    logic signed [ecv_pkg::OUT_W-1:0] position;
  } reading_t;

  logic                             clk;
  logic                             rst_n;
  logic                             push;
  logic                             full;
  logic                             in_cmd;
  logic                             in_chan_a_level;
  logic                             in_chan_b_level;
  logic [ecv_pkg::TIME_W-1:0]       in_time_us;
  logic                             empty;
  logic                             pop;
  logic signed [ecv_pkg::OUT_W-1:0] out_velocity_mrad_s;
  logic signed [ecv_pkg::OUT_W-1:0] out_position_count;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [ecv_pkg::PADDR_W-1:0]      paddr;
  logic [ecv_pkg::PDATA_W-1:0]      pwdata;
  logic [ecv_pkg::PDATA_W-1:0]      prdata;
  logic                             pready;

  logic [ecv_pkg::SCALE_W-1:0]         scale          = ecv_pkg::SCALE_RESET;
  logic [ecv_pkg::COUNT_WIDTH_DEF-1:0] enc_count      = '0;
  logic [ecv_pkg::COUNT_WIDTH_DEF-1:0] count_at_query = '0;
  logic [ecv_pkg::TIME_W-1:0]          time_at_query  = '0;
  reading_t                            readings_due[$];

  int                         errors         = 0;
  int                         cycles         = 0;
  int                         send_idle_pct  = 0;
  int                         recv_stall_pct = 0;
  int                         hold_left      = 0;
  logic [ecv_pkg::TIME_W-1:0] stamp          = '0;

  encoder_count_and_velocity DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_cmd              (in_cmd),
    .in_chan_a_level     (in_chan_a_level),
    .in_chan_b_level     (in_chan_b_level),
    .in_time_us          (in_time_us),
    .empty               (empty),
    .pop                 (pop),
    .out_velocity_mrad_s (out_velocity_mrad_s),
    .out_position_count  (out_position_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[encoder_count_and_velocity] ERROR");
      $finish;
    end
  end

  function automatic logic signed [ecv_pkg::OUT_W-1:0] scaled_velocity(
    input logic signed [ecv_pkg::COUNT_WIDTH_DEF-1:0] delta,
    input logic [ecv_pkg::TIME_W-1:0]                 elapsed,
    input logic [ecv_pkg::SCALE_W-1:0]                sc
  );
    longint unsigned mag;
    longint unsigned ceiling;
    longint unsigned rate;
    mag = longint'(delta);
    if (delta < 0) begin
      mag     = 0 - mag;
      ceiling = 64'h8000_0000;
    end else begin
      ceiling = 64'h7fff_ffff;
    end
    rate = (mag * sc) / elapsed;
    if (rate > ceiling) rate = ceiling;
    return (delta < 0) ? ecv_pkg::OUT_W'(0 - rate) : ecv_pkg::OUT_W'(rate);
  endfunction

  function automatic void track_word(input ecv_pkg::cmd_t c, input logic a, input logic b,
                                     input logic [ecv_pkg::TIME_W-1:0] t);
    logic signed [ecv_pkg::COUNT_WIDTH_DEF-1:0] delta;
    reading_t                                   r;
    if (c == ecv_pkg::CMD_EDGE) begin
      enc_count = (a == b) ? enc_count + 1'b1 : enc_count - 1'b1;
    end else begin
      delta          = enc_count - count_at_query;
      count_at_query = enc_count;
      r.velocity     = '0;
      if (t != time_at_query) begin
        r.velocity    = scaled_velocity(delta, t - time_at_query, scale);
        time_at_query = t;
      end
      r.position = ecv_pkg::OUT_W'(signed'(enc_count));
      readings_due.push_back(r);
    end
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && pop && !empty) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected word, velocity %0d position %0d", $time,
                 out_velocity_mrad_s, out_position_count);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (out_velocity_mrad_s !== want.velocity) begin
          $display("%0t: velocity expected %0d, got %0d", $time, want.velocity,
                   out_velocity_mrad_s);
          errors++;
        end
        if (out_position_count !== want.position) begin
          $display("%0t: position expected %0d, got %0d", $time, want.position,
                   out_position_count);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input ecv_pkg::cmd_t c, input logic a, input logic b,
                           input logic [ecv_pkg::TIME_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    in_cmd          <= c;
    in_chan_a_level <= a;
    in_chan_b_level <= b;
    in_time_us      <= t;
    do @(posedge clk); while (full);
    track_word(c, a, b, t);
  endtask

  task automatic send_edge(input bit up);
    logic a;
    a = 1'($urandom_range(1));
    send_word(ecv_pkg::CMD_EDGE, a, up ? a : !a, $urandom);
  endtask

  task automatic send_query(input logic [ecv_pkg::TIME_W-1:0] t);
    stamp = t;
    send_word(ecv_pkg::CMD_QUERY, 1'($urandom_range(1)), 1'($urandom_range(1)), t);
  endtask

  // hold the sender off until every reading is back and the back end is quiet
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [ecv_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ecv_pkg::PADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ecv_pkg::REG_SCALE) scale = value[ecv_pkg::SCALE_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_scale();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ecv_pkg::PADDR_W'(4 * ecv_pkg::REG_SCALE);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ecv_pkg::PDATA_W'(scale)) begin
      $display("%0t: scale register expected %0d, got %0d", $time, scale, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [ecv_pkg::TIME_W-1:0] pick_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return stamp;
    if (r < 20) return $urandom;
    if (r < 35) return stamp + $urandom_range(1, 8);
    return stamp + $urandom_range(1, 5000);
  endfunction

  task automatic test_register_access();
    check_scale();
    cfg_write(SPARE_REG, 32'h0000_1234);
    check_scale();
    cfg_write(ecv_pkg::REG_SCALE, 32'hffff_ffff);
    check_scale();
    cfg_write(ecv_pkg::REG_SCALE, ecv_pkg::PDATA_W'(ecv_pkg::SCALE_RESET));
    check_scale();
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(ecv_pkg::CMD_QUERY, 1'b1, 1'b0, 32'h0000_0000);
    send_word(ecv_pkg::CMD_EDGE, 1'b0, 1'b0, 32'hffff_ffff);
    send_word(ecv_pkg::CMD_EDGE, 1'b1, 1'b1, 32'h0000_0000);
    send_word(ecv_pkg::CMD_EDGE, 1'b1, 1'b1, $urandom);
    send_word(ecv_pkg::CMD_QUERY, 1'b1, 1'b1, 32'h0000_0001);
    send_word(ecv_pkg::CMD_EDGE, 1'b0, 1'b1, 32'hffff_ffff);
    send_word(ecv_pkg::CMD_EDGE, 1'b1, 1'b0, 32'h0000_0000);
    send_word(ecv_pkg::CMD_QUERY, 1'b0, 1'b0, 32'h0000_0001);
    send_word(ecv_pkg::CMD_QUERY, 1'b0, 1'b1, 32'hffff_ffff);
    send_word(ecv_pkg::CMD_EDGE, 1'b0, 1'b1, $urandom);
    send_word(ecv_pkg::CMD_EDGE, 1'b1, 1'b0, $urandom);
    send_word(ecv_pkg::CMD_EDGE, 1'b0, 1'b1, $urandom);
    send_word(ecv_pkg::CMD_QUERY, 1'b1, 1'b0, 32'h0000_0010);
    send_word(ecv_pkg::CMD_QUERY, 1'b1, 1'b1, 32'h0000_0011);
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, 32'h0000_0000);
    send_edge(1'b1);
    send_edge(1'b1);
    send_query(32'h0000_0020);
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, 32'h00ff_ffff);
    send_edge(1'b0);
    send_query(32'h0000_0021);
  endtask

  task automatic test_saturation();
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, 32'h00ff_ffff);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (130) send_edge(1'b1);
    send_query(stamp + 1);
    repeat (130) send_edge(1'b0);
    send_query(stamp + 1);
  endtask

  task automatic run_traffic(input int words, input int idle_pct, input int stall_pct);
    int sent;
    int run;
    bit up;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    while (sent < words) begin
      run = $urandom_range(0, 5);
      up  = 1'($urandom_range(1));
      repeat (run) begin
        send_edge(($urandom_range(3) != 0) ? up : !up);
        sent++;
      end
      send_query(pick_stamp());
      sent++;
    end
  endtask

  task automatic test_idle_phases();
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, ecv_pkg::PDATA_W'(ecv_pkg::SCALE_RESET));
    run_traffic(60, 0, 0);
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, $urandom_range(1, 24'hff_ffff));
    run_traffic(60, 54, 0);
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, 32'h0000_0001);
    run_traffic(60, 0, 54);
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, $urandom);
    run_traffic(60, 30, 30);
  endtask

  task automatic test_backpressure();
    wait_drained();
    cfg_write(ecv_pkg::REG_SCALE, ecv_pkg::PDATA_W'(ecv_pkg::SCALE_RESET));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 1500;
    repeat (24) begin
      send_edge(1'($urandom_range(1)));
      send_query(stamp + $urandom_range(1, 100));
    end
    wait_drained();
    run_traffic(12, 0, 0);
  endtask

  initial begin
    rst_n           = 1'b0;
    push            = 1'b0;
    in_cmd          = ecv_pkg::CMD_EDGE;
    in_chan_a_level = 1'b0;
    in_chan_b_level = 1'b0;
    in_time_us      = '0;
    pop             = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed();
    test_saturation();
    test_idle_phases();
    test_backpressure();
    wait_drained();

    if (errors == 0) begin
      $display("[encoder_count_and_velocity] OK");
    end else begin
      $display("[encoder_count_and_velocity] ERROR");
    end
    $finish;
  end

endmodule
